/* hw/rtl/rpbr_pkg.sv */
// ---------------------------------------------------------------------------
// rpbr_pkg
// Shared types and constants for the backward reachability pruning block.
// ---------------------------------------------------------------------------
package rpbr_pkg;

   localparam int VAR_W  = 6;   // variable index width
   localparam int NV_W   = 7;   // num_vars register width
   localparam int CNT_W  = 6;   // level and successor count width
   localparam int CMD_W  = 2;
   localparam int ROW_MAX = 64; // widest edge row the fields can address

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD_EDGE  = 2'd0,
      CMD_MARK_ROOT = 2'd1,
      CMD_RUN       = 2'd2,
      CMD_CLEAR     = 2'd3
   } cmd_type;

   typedef enum logic {
      REG_NUM_VARS = 1'b0,
      REG_KEEP_ALL = 1'b1
   } reg_index_type;

   // broadcast control from the sequencer to every cell
   typedef struct packed {
      logic             clear;
      logic             edge_we;
      logic             root_we;
      logic [VAR_W-1:0] src;
      logic [VAR_W-1:0] tgt;
      logic             seed;
      logic             step;
      logic             count;
      logic             load;
      logic             shift;
      logic             keep_all;
      logic             shown_k;
      logic [NV_W-1:0]  n;
   } cell_ctrl_type;

endpackage

/* hw/rtl/relevance_pruning_by_backward_reach.sv */
// ---------------------------------------------------------------------------
// relevance_pruning_by_backward_reach
// Loads dependency edges and root marks, then marks every variable that
// reaches a root (all active ones under keep_all) and reports each active one.
// ---------------------------------------------------------------------------
// Edge, root and clear commands are accepted back to back while idle. A run
// with n active variables has a propagation phase, in which every cell ORs
// its row against the necessary vector, a count phase, in which each cell
// scans its row one bit a cycle to count necessary successors, and n result
// transfers as the result slots shift along the chain of cells towards the
// output register, which the sink can stall. The block takes a new command
// once the last result of a run has entered the output register. Each cell
// holds its own edge row in flip-flops, so reset and the clear command empty
// the graph at once.
module relevance_pruning_by_backward_reach #(
   parameter int MAX_VARS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // command[1:0], src_var[7:2], target_var[13:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // var_index[5:0], necessary[6], level[12:7],
                                    // succ_count[18:13]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [6:0]  csr_wdata
);

   localparam int CELLS = (MAX_VARS < rpbr_pkg::ROW_MAX) ? MAX_VARS : rpbr_pkg::ROW_MAX;
   localparam logic [rpbr_pkg::NV_W-1:0] N_CAP = rpbr_pkg::NV_W'(CELLS);
   localparam int VW = rpbr_pkg::VAR_W;
   localparam int NW = rpbr_pkg::NV_W;
   localparam int CW = rpbr_pkg::CNT_W;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_REACH = 4'b0010,
      ST_COUNT = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [NW-1:0]          nv_ff, nv_in;
   logic                   keep_ff, keep_in;
   logic [NW-1:0]          steps_ff, steps_in;
   logic [VW-1:0]          k_ff, k_in;
   logic [NW-1:0]          left_ff, left_in;
   logic [VW-1:0]          idx_ff, idx_in;
   logic [CW-1:0]          rank_ff, rank_in;
   logic                   rvalid_ff, rvalid_in;
   logic [23:0]            rdata_ff, rdata_in;
   logic                   rlast_ff, rlast_in;

   rpbr_pkg::cmd_type       cmd;
   logic [VW-1:0]           src, tgt;
   logic                    accept, emit_load;
   logic [NW-1:0]           n;
   rpbr_pkg::cell_ctrl_type ctrl;
   logic [CELLS-1:0]        need_vec, scan_vec;
   logic                    sh_nec_a [0:CELLS];
   logic [CW-1:0]           sh_cnt_a [0:CELLS];

   assign cmd    = rpbr_pkg::cmd_type'(req_tdata[1:0]);
   assign src    = req_tdata[7:2];
   assign tgt    = req_tdata[13:8];
   assign accept = req_tvalid && req_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;

   // zero acts as one, anything above the cell count is capped
   assign n = (nv_ff == '0) ? NW'(1) : ((nv_ff > N_CAP) ? N_CAP : nv_ff);

   always_comb begin
      for (int j = 0; j < CELLS; j++) begin
         scan_vec[j] = (k_ff == VW'(j));
      end
   end

   assign emit_load = (state_ff == ST_EMIT) && (left_ff != '0) &&
                      (!rvalid_ff || rsp_tready);

   always_comb begin
      ctrl          = '0;
      ctrl.clear    = accept && (cmd == rpbr_pkg::CMD_CLEAR);
      ctrl.edge_we  = accept && (cmd == rpbr_pkg::CMD_ADD_EDGE) && (src != tgt);
      ctrl.root_we  = accept && (cmd == rpbr_pkg::CMD_MARK_ROOT);
      ctrl.src      = src;
      ctrl.tgt      = tgt;
      ctrl.seed     = accept && (cmd == rpbr_pkg::CMD_RUN);
      ctrl.step     = (state_ff == ST_REACH);
      ctrl.count    = (state_ff == ST_COUNT);
      ctrl.load     = (state_ff == ST_COUNT) && (k_ff == '0);
      ctrl.shift    = emit_load;
      ctrl.keep_all = keep_ff;
      ctrl.shown_k  = keep_ff || (|(need_vec & scan_vec));
      ctrl.n        = n;
   end

   assign sh_nec_a[CELLS] = 1'b0;
   assign sh_cnt_a[CELLS] = '0;

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      rpbr_cell #(
         .INDEX (i),
         .CELLS (CELLS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .need_vec (need_vec),
         .scan_vec (scan_vec),
         .sh_nec_i (sh_nec_a[i+1]),
         .sh_cnt_i (sh_cnt_a[i+1]),
         .need_o   (need_vec[i]),
         .sh_nec_o (sh_nec_a[i]),
         .sh_cnt_o (sh_cnt_a[i])
      );
   end

   always_comb begin
      state_in  = state_ff;
      nv_in     = nv_ff;
      keep_in   = keep_ff;
      steps_in  = steps_ff;
      k_in      = k_ff;
      left_in   = left_ff;
      idx_in    = idx_ff;
      rank_in   = rank_ff;
      rvalid_in = rvalid_ff;
      rdata_in  = rdata_ff;
      rlast_in  = rlast_ff;

      if (csr_valid && csr_ready) begin
         case (rpbr_pkg::reg_index_type'(csr_index))
            rpbr_pkg::REG_NUM_VARS: nv_in   = csr_wdata;
            rpbr_pkg::REG_KEEP_ALL: keep_in = csr_wdata[0];
            default:                nv_in   = nv_ff;
         endcase
      end

      if (rvalid_ff && rsp_tready) begin
         rvalid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && (cmd == rpbr_pkg::CMD_RUN)) begin
               state_in = ST_REACH;
               steps_in = n;
            end
         end
         ST_REACH: begin
            steps_in = steps_ff - NW'(1);
            if (steps_ff == NW'(1)) begin
               state_in = ST_COUNT;
               k_in     = '0;
            end
         end
         ST_COUNT: begin
            k_in = k_ff + VW'(1);
            if ({1'b0, k_ff} == n - NW'(1)) begin
               state_in = ST_EMIT;
               left_in  = n;
               idx_in   = '0;
               rank_in  = '0;
            end
         end
         ST_EMIT: begin
            if (emit_load) begin
               rvalid_in = 1'b1;
               rdata_in  = {5'd0, sh_cnt_a[0],
                            sh_nec_a[0] ? rank_ff : CW'(0),
                            sh_nec_a[0], idx_ff};
               rlast_in  = (left_ff == NW'(1));
               rank_in   = rank_ff + CW'(sh_nec_a[0]);
               idx_in    = idx_ff + VW'(1);
               left_in   = left_ff - NW'(1);
            end
            if (left_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         nv_ff     <= NW'(64);
         keep_ff   <= 1'b0;
         rvalid_ff <= 1'b0;
         steps_ff  <= '0;
         k_ff      <= '0;
         left_ff   <= '0;
         idx_ff    <= '0;
         rank_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         nv_ff     <= nv_in;
         keep_ff   <= keep_in;
         rvalid_ff <= rvalid_in;
         steps_ff  <= steps_in;
         k_ff      <= k_in;
         left_ff   <= left_in;
         idx_ff    <= idx_in;
         rank_ff   <= rank_in;
      end
      rdata_ff <= rdata_in;
      rlast_ff <= rlast_in;
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rdata_ff;
   assign rsp_tlast  = rlast_ff;

endmodule

/* hw/rtl/rpbr_cell.sv */
// ---------------------------------------------------------------------------
// rpbr_cell
// One variable: its edge row, root and necessary marks, successor counter
// and a result slot that shifts towards cell zero during emission.
// ---------------------------------------------------------------------------
module rpbr_cell #(
   parameter int INDEX = 0,
   parameter int CELLS = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  rpbr_pkg::cell_ctrl_type      ctrl,
   input  logic [CELLS-1:0]             need_vec,
   input  logic [CELLS-1:0]             scan_vec,
   input  logic                         sh_nec_i,
   input  logic [rpbr_pkg::CNT_W-1:0]   sh_cnt_i,
   output logic                         need_o,
   output logic                         sh_nec_o,
   output logic [rpbr_pkg::CNT_W-1:0]   sh_cnt_o
);

   localparam logic [rpbr_pkg::NV_W-1:0]  IDX_N = rpbr_pkg::NV_W'(INDEX);
   localparam logic [rpbr_pkg::VAR_W-1:0] IDX_V = rpbr_pkg::VAR_W'(INDEX);

   logic [CELLS-1:0]           row_ff, row_in, tgt_dec;
   logic                       root_ff, root_in;
   logic                       need_ff, need_in;
   logic                       nec_ff, nec_in;
   logic [rpbr_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                       active, mine, hit, bit_k;

   always_comb begin
      for (int j = 0; j < CELLS; j++) begin
         tgt_dec[j] = (ctrl.tgt == rpbr_pkg::VAR_W'(j));
      end
   end

   assign active = (IDX_N < ctrl.n);
   assign mine   = (ctrl.src == IDX_V);
   assign hit    = |(row_ff & need_vec);
   assign bit_k  = |(row_ff & scan_vec);

   always_comb begin
      row_in  = row_ff;
      root_in = root_ff;
      need_in = need_ff;
      nec_in  = nec_ff;
      cnt_in  = cnt_ff;
      if (ctrl.clear) begin
         row_in  = '0;
         root_in = 1'b0;
         need_in = 1'b0;
      end else begin
         if (ctrl.edge_we && mine) begin
            row_in = row_ff | tgt_dec;
         end
         if (ctrl.root_we && mine) begin
            root_in = 1'b1;
         end
      end
      if (ctrl.seed) begin
         need_in = root_ff & active;
         cnt_in  = '0;
      end else if (ctrl.step) begin
         need_in = need_ff | (active & hit);
      end
      if (ctrl.count) begin
         cnt_in = cnt_ff + rpbr_pkg::CNT_W'(bit_k & ctrl.shown_k);
      end
      if (ctrl.load) begin
         nec_in = ctrl.keep_all ? active : need_ff;
      end
      if (ctrl.shift) begin
         nec_in = sh_nec_i;
         cnt_in = sh_cnt_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         root_ff <= 1'b0;
         need_ff <= 1'b0;
      end else begin
         row_ff  <= row_in;
         root_ff <= root_in;
         need_ff <= need_in;
      end
      nec_ff <= nec_in;
      cnt_ff <= cnt_in;
   end

   assign need_o   = need_ff;
   assign sh_nec_o = nec_ff;
   assign sh_cnt_o = cnt_ff;

endmodule
